[src/pcsh_pkg.sv]
// Package for the potentiometer calibrate, smooth and hysteresis block.
// Holds controller state and command types, register indexes and fixed constants.
// No dependencies.
package pcsh_pkg;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CAL,
    ST_STEP,
    ST_UPD
  } ctrl_state_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CAL_OFFSET = 2'd0,
    REG_CAL_GAIN   = 2'd1,
    REG_HYST_WIDTH = 2'd2
  } cfg_reg_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming sample
    logic cal;     // calibrate: offset, gain, clamp
    logic step;    // smoother step product
    logic upd;     // update level, window and result
  } ctrl_cmd_t;

  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 24;
  localparam int unsigned LevelW  = 32;
  localparam int unsigned CfgIdxW = 2;

  // Smoother coefficient 3277/65536, signed form for the signed multiply
  localparam logic signed [13:0] AlphaQ16 = 14'sd3277;
  // 65535.0 in Q16.16
  localparam logic [LevelW-1:0] LevelMaxQ16 = 32'hFFFF_0000;

  localparam logic [SampleW-1:0] CalOffsetRst = 16'd0;
  localparam logic [GainW-1:0]   CalGainRst   = 24'd65536;
  localparam logic [SampleW-1:0] HystWidthRst = 16'd128;

endpackage

[src/pcsh_ctrl.sv]
// Controller for the potentiometer conditioning block.
// Sequences load, calibrate, smoother step and update; owns the output valid.
// Depends on pcsh_pkg.
module pcsh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pcsh_pkg::ctrl_cmd_t cmd_o
);

  pcsh_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pcsh_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pcsh_pkg::ST_CAL;
      end
      pcsh_pkg::ST_CAL:  state_d = pcsh_pkg::ST_STEP;
      pcsh_pkg::ST_STEP: state_d = pcsh_pkg::ST_UPD;
      pcsh_pkg::ST_UPD: begin
        if (out_free) state_d = pcsh_pkg::ST_IDLE;
      end
      default: state_d = pcsh_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      pcsh_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      pcsh_pkg::ST_CAL:  cmd_o.cal  = 1'b1;
      pcsh_pkg::ST_STEP: cmd_o.step = 1'b1;
      pcsh_pkg::ST_UPD:  cmd_o.upd  = out_free;
      default: ;
    endcase
  end

  // Hold the result valid until the request is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.upd) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcsh_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == pcsh_pkg::ST_CAL))
    else $error("accepted request did not start calibration");

  a_upd_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.upd |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_upd_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.upd |=> (out_valid_q && state_q == pcsh_pkg::ST_IDLE))
    else $error("update did not present a result");

endmodule

[src/pcsh_dpath.sv]
// Datapath for the potentiometer conditioning block: configuration registers,
// calibration multiply, smoother multiply, level and window state, result register.
// Depends on pcsh_pkg.
module pcsh_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcsh_pkg::ctrl_cmd_t                 cmd_i,
  input  logic                                cfg_we_i,
  input  logic [pcsh_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pcsh_pkg::GainW-1:0]          cfg_data_i,
  input  logic [pcsh_pkg::SampleW-1:0]        sample_i,
  output logic                                changed_o,
  output logic [pcsh_pkg::SampleW-1:0]        level_o
);

  logic [pcsh_pkg::SampleW-1:0] cal_offset_q;
  logic [pcsh_pkg::GainW-1:0]   cal_gain_q;
  logic [pcsh_pkg::SampleW-1:0] hyst_width_q;

  logic [pcsh_pkg::SampleW-1:0] sample_q;
  logic [pcsh_pkg::LevelW-1:0]  target_q, target_d;
  logic signed [30:0]           step_q, step_d;
  logic [pcsh_pkg::LevelW-1:0]  filt_q, filt_d;
  logic [pcsh_pkg::LevelW-1:0]  win_lo_q, win_lo_d;
  logic [pcsh_pkg::LevelW-1:0]  win_hi_q, win_hi_d;
  logic                         changed_q, changed_d;
  logic [pcsh_pkg::SampleW-1:0] level_q;

  logic [pcsh_pkg::SampleW:0]   diff;
  logic [39:0]                  cal_prod;
  logic signed [32:0]           err;
  logic signed [46:0]           err_prod;
  logic signed [33:0]           f_sum;
  logic [30:0]                  half;
  logic [32:0]                  lo_raw, hi_raw;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_offset_q <= pcsh_pkg::CalOffsetRst;
      cal_gain_q   <= pcsh_pkg::CalGainRst;
      hyst_width_q <= pcsh_pkg::HystWidthRst;
    end else if (cfg_we_i) begin
      case (pcsh_pkg::cfg_reg_e'(cfg_index_i))
        pcsh_pkg::REG_CAL_OFFSET: cal_offset_q <= cfg_data_i[pcsh_pkg::SampleW-1:0];
        pcsh_pkg::REG_CAL_GAIN:   cal_gain_q   <= cfg_data_i;
        pcsh_pkg::REG_HYST_WIDTH: hyst_width_q <= cfg_data_i[pcsh_pkg::SampleW-1:0];
        default: ;
      endcase
    end
  end

  // Calibrate: subtract offset, apply gain, clamp to 0 .. 65535.0
  always_comb begin
    diff     = {1'b0, sample_q} - {1'b0, cal_offset_q};
    cal_prod = 40'(diff[pcsh_pkg::SampleW-1:0]) * 40'(cal_gain_q);
    if (diff[pcsh_pkg::SampleW]) begin
      target_d = '0;
    end else if (cal_prod > 40'(pcsh_pkg::LevelMaxQ16)) begin
      target_d = pcsh_pkg::LevelMaxQ16;
    end else begin
      target_d = cal_prod[pcsh_pkg::LevelW-1:0];
    end
  end

  // Smoother step: floor((target - level) * alpha / 65536)
  always_comb begin
    err      = $signed({1'b0, target_q}) - $signed({1'b0, filt_q});
    err_prod = 47'(err) * 47'(pcsh_pkg::AlphaQ16);
    step_d   = err_prod[46:16];
  end

  // Update level, test the window and place a new one when left
  always_comb begin
    f_sum = $signed({2'b00, filt_q}) + 34'(step_q);
    if (f_sum < 0) begin
      filt_d = '0;
    end else if (f_sum > $signed({2'b00, pcsh_pkg::LevelMaxQ16})) begin
      filt_d = pcsh_pkg::LevelMaxQ16;
    end else begin
      filt_d = f_sum[pcsh_pkg::LevelW-1:0];
    end
    half      = {hyst_width_q, 15'b0};
    lo_raw    = {1'b0, filt_d} - {2'b00, half};
    hi_raw    = {1'b0, filt_d} + {2'b00, half};
    changed_d = (filt_d < win_lo_q) || (filt_d > win_hi_q);
    win_lo_d  = win_lo_q;
    win_hi_d  = win_hi_q;
    if (changed_d) begin
      win_lo_d = lo_raw[32] ? '0 : lo_raw[pcsh_pkg::LevelW-1:0];
      win_hi_d = (hi_raw > {1'b0, pcsh_pkg::LevelMaxQ16}) ? pcsh_pkg::LevelMaxQ16
                                                           : hi_raw[pcsh_pkg::LevelW-1:0];
    end
  end

  // Level and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q   <= '0;
      win_lo_q <= '0;
      win_hi_q <= '0;
    end else if (cmd_i.upd) begin
      filt_q   <= filt_d;
      win_lo_q <= win_lo_d;
      win_hi_q <= win_hi_d;
    end
  end

  // Pipeline payload and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) sample_q <= sample_i;
    if (cmd_i.cal)  target_q <= target_d;
    if (cmd_i.step) step_q   <= step_d;
    if (cmd_i.upd) begin
      changed_q <= changed_d;
      level_q   <= filt_d[pcsh_pkg::LevelW-1:pcsh_pkg::SampleW];
    end
  end

  assign changed_o = changed_q;
  assign level_o   = level_q;

endmodule

[src/pot_calibrate_smooth_hysteresis_core.sv]
// Potentiometer conditioning block: offset and gain calibration, a one-pole
// smoother with alpha 3277/65536 in Q16.16, and a hysteresis window that flags
// changes of the smoothed level. A request is loaded at the accepting edge in
// the idle cycle; the calibration multiply, the smoother multiply and the
// update follow in turn, and the update registers the result and offers it.
// The update waits while the output register holds an untaken result, and
// one request is in work at a time: a new one is accepted only after the
// previous update. A finished result waits in the output register while the
// next request is accepted. Depends on pcsh_pkg, pcsh_ctrl, pcsh_dpath.
module pot_calibrate_smooth_hysteresis_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] level
  output logic        m_axis_tuser_o,   // [0] changed
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  pcsh_pkg::ctrl_cmd_t cmd;

  // Take configuration writes at any time
  assign cfg_ready_o = 1'b1;

  pcsh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  pcsh_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (s_axis_tdata_i),
    .changed_o   (m_axis_tuser_o),
    .level_o     (m_axis_tdata_o)
  );

endmodule

[test/testbench.sv]
// Testbench for pot_calibrate_smooth_hysteresis_core: directed rows, then random
// phases of samples, each result checked against an in-bench level predictor.
// Depends on pcsh_pkg and the core RTL.
module testbench;

  localparam int  CycleLimit  = 400000;
  localparam int  RandPhases  = 10;
  localparam int  PhaseItems  = 110;
  localparam int  HoldResults = 120;
  localparam int  HoldCycles  = 400;

  typedef struct packed {
    logic        changed;
    logic [15:0] level;
  } level_rpt_t;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    pcsh_pkg::cfg_reg_e reg_idx;
    logic [23:0]        value;
    logic               typed;
    level_rpt_t         rpt;
  } dir_row_t;

  localparam level_rpt_t NoRpt = '0;

  // Directed rows: extremes, offset and gain saturation, zero and full width
  dir_row_t dir_rows [28] = '{
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd0,        1'b1, '{1'b0, 16'd0}},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd65535,    1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd65535,    1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd32768,    1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd0,        1'b0, NoRpt},
    '{ROW_REG,    pcsh_pkg::REG_CAL_OFFSET, 24'd1000,     1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd500,      1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd1000,     1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd1001,     1'b0, NoRpt},
    '{ROW_REG,    pcsh_pkg::REG_CAL_GAIN,   24'hFFFFFF,   1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd65535,    1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd1001,     1'b0, NoRpt},
    '{ROW_REG,    pcsh_pkg::REG_HYST_WIDTH, 24'd0,        1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd1001,     1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd1001,     1'b0, NoRpt},
    '{ROW_REG,    pcsh_pkg::REG_HYST_WIDTH, 24'd65535,    1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd40000,    1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd0,        1'b0, NoRpt},
    '{ROW_REG,    pcsh_pkg::REG_CAL_GAIN,   24'd0,        1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd65535,    1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd65535,    1'b0, NoRpt},
    '{ROW_REG,    pcsh_pkg::REG_CAL_OFFSET, 24'd65535,    1'b0, NoRpt},
    '{ROW_REG,    pcsh_pkg::REG_CAL_GAIN,   24'd65536,    1'b0, NoRpt},
    '{ROW_REG,    pcsh_pkg::REG_HYST_WIDTH, 24'd128,      1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd65535,    1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd0,        1'b0, NoRpt},
    '{ROW_REG,    pcsh_pkg::REG_CAL_OFFSET, 24'd0,        1'b0, NoRpt},
    '{ROW_SAMPLE, pcsh_pkg::REG_CAL_OFFSET, 24'd12345,    1'b0, NoRpt}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_data = '0;
  logic        m_axis_tvalid_o;
  logic        m_tready = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  // Predictor copy of the registers and the Q16.16 state
  logic [15:0] ofs_reg;
  logic [23:0] gain_reg;
  logic [15:0] width_reg;
  logic [31:0] filt_lvl;
  logic [31:0] win_lo;
  logic [31:0] win_hi;

  level_rpt_t level_q [$];
  int         err_count = 0;
  int         rpt_count = 0;
  int         cycle_count = 0;

  pot_calibrate_smooth_hysteresis_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Calibrate, smooth and test the window for one sample; advance the state
  function automatic level_rpt_t smooth_sample(logic [15:0] sample);
    level_rpt_t rpt;
    longint     lvl_max;
    longint     target;
    longint     f;
    longint     half;
    longint     lo;
    longint     hi;
    lvl_max = longint'(pcsh_pkg::LevelMaxQ16);
    target  = longint'(sample) - longint'(ofs_reg);
    if (target <= 0) begin
      target = 0;
    end else begin
      target = target * longint'(gain_reg);
      if (target > lvl_max) target = lvl_max;
    end
    // arithmetic shift of a signed product floors towards minus infinity
    f = longint'(filt_lvl);
    f = f + (((target - f) * longint'(pcsh_pkg::AlphaQ16)) >>> 16);
    if (f < 0) f = 0;
    if (f > lvl_max) f = lvl_max;
    filt_lvl = 32'(f);
    rpt.changed = 1'b0;
    if (f < longint'(win_lo) || f > longint'(win_hi)) begin
      half = longint'(width_reg) * 32768;
      lo   = f - half;
      hi   = f + half;
      if (lo < 0) lo = 0;
      if (hi > lvl_max) hi = lvl_max;
      win_lo = 32'(lo);
      win_hi = 32'(hi);
      rpt.changed = 1'b1;
    end
    rpt.level = filt_lvl[31:16];
    return rpt;
  endfunction

  // Offer one sample after a gap and record its expected report on accept
  task automatic push_sample(input logic [15:0] sample, input int gap,
                             input logic typed, input level_rpt_t typed_rpt);
    level_rpt_t rpt;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= sample;
    do @(posedge clk_i); while (!s_axis_tready_o);
    rpt = smooth_sample(sample);
    level_q.push_back(typed ? typed_rpt : rpt);
  endtask

  // Drop the request and hold until every pending report has arrived
  task automatic settle();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (level_q.size() != 0);
  endtask

  task automatic write_reg(input pcsh_pkg::cfg_reg_e idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pcsh_pkg::REG_CAL_OFFSET: ofs_reg   = val[15:0];
      pcsh_pkg::REG_CAL_GAIN:   gain_reg  = val;
      pcsh_pkg::REG_HYST_WIDTH: width_reg = val[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly short gaps, some longer ones, none in calm stretches
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Report side: check each accepted report, stall at random
  initial begin : report_sink
    level_rpt_t want;
    int         stall_left;
    bit         calm;
    bit         hold_done;
    stall_left = 0;
    calm       = 1'b0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_tready) begin
        rpt_count++;
        if (level_q.size() == 0) begin
          $error("report with none pending: level %0d", m_axis_tdata_o);
          err_count++;
        end else begin
          want = level_q.pop_front();
          if (m_axis_tuser_o !== want.changed) begin
            $error("changed: expected %0d, got %0d", want.changed, m_axis_tuser_o);
            err_count++;
          end
          if (m_axis_tdata_o !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, m_axis_tdata_o);
            err_count++;
          end
        end
      end
      if ($urandom_range(0, 149) == 0) calm = !calm;
      if (!hold_done && rpt_count >= HoldResults) begin
        // long hold-off so the core backs up into its input
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Sample side: reset, directed rows, then random phases
  initial begin : sample_source
    int          i;
    int          n;
    int          r;
    bit          calm;
    int          walk;
    logic [15:0] sample;
    ofs_reg   = pcsh_pkg::CalOffsetRst;
    gain_reg  = pcsh_pkg::CalGainRst;
    width_reg = pcsh_pkg::HystWidthRst;
    filt_lvl  = '0;
    win_lo    = '0;
    win_hi    = '0;
    walk      = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < $size(dir_rows); i++) begin
      if (dir_rows[i].kind == ROW_REG) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        push_sample(dir_rows[i].value[15:0], pick_gap(1'b0),
                    dir_rows[i].typed, dir_rows[i].rpt);
      end
    end

    for (i = 0; i < RandPhases; i++) begin
      settle();
      // Offset: mostly zero or small, sometimes full scale
      r = $urandom_range(0, 9);
      write_reg(pcsh_pkg::REG_CAL_OFFSET, (r == 0) ? 24'd65535 :
                                          (r < 5)  ? 24'd0 :
                                          (r < 8)  ? 24'($urandom_range(0, 2000)) :
                                                     24'($urandom_range(0, 65535)));
      // Gain: often near unity, often random, with both extremes
      r = $urandom_range(0, 9);
      write_reg(pcsh_pkg::REG_CAL_GAIN, (r == 0) ? 24'd0 :
                                        (r == 1) ? 24'hFFFFFF :
                                        (r < 6)  ? 24'($urandom_range(40000, 100000)) :
                                                   24'($urandom_range(0, 24'hFFFFFF)));
      r = $urandom_range(0, 9);
      write_reg(pcsh_pkg::REG_HYST_WIDTH, (r == 0) ? 24'd0 :
                                          (r == 1) ? 24'd65535 :
                                          (r < 6)  ? 24'($urandom_range(1, 512)) :
                                                     24'($urandom_range(0, 65535)));
      calm = (i % 3 == 0);
      for (n = 0; n < PhaseItems; n++) begin
        if (i == 1 && n == PhaseItems / 2) settle();
        // Slow drift around a level, with jumps and full-range noise
        r = $urandom_range(0, 19);
        if (r == 0) begin
          sample = 16'($urandom_range(0, 65535));
        end else begin
          if (r == 1) walk = $urandom_range(0, 65535);
          else walk = walk + $urandom_range(0, 64) - 32;
          if (walk < 0) walk = 0;
          if (walk > 65535) walk = 65535;
          sample = 16'(walk);
        end
        push_sample(sample, pick_gap(calm), 1'b0, NoRpt);
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && level_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
src/pcsh_pkg.sv
src/pcsh_ctrl.sv
src/pcsh_dpath.sv
src/pot_calibrate_smooth_hysteresis_core.sv
test/testbench.sv
